// ===== hdl/pbbt_pkg.sv =====
// Shared types, constants and codes for the per-color bounding box table.
package pbbt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int COORD_BITS    = 12;
  localparam int COLOR_BITS    = 24;
  localparam int SPAN_BITS     = COORD_BITS + 1;
  localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES + 1);

  localparam int IN_DATA_BITS  = ((COLOR_BITS + 2 * COORD_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((6 * COORD_BITS + SPAN_BITS + 7) / 8) * 8;

  typedef enum logic [1:0] {
    CMD_PIXEL = 2'd0,
    CMD_QUERY = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_EXISTING  = 2'd0,
    ST_NEW       = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef struct packed {
    logic                    clear;
    logic                    write;
    logic [COLOR_BITS-1:0]   color;
    logic [COORD_BITS-1:0]   x;
    logic [COORD_BITS-1:0]   y;
  } bbt_req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] min_x;
    logic [COORD_BITS-1:0] min_y;
    logic [COORD_BITS-1:0] max_x;
    logic [COORD_BITS-1:0] max_y;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
  } bbt_entry_t;

endpackage

// ===== hdl/pbbt_cell.sv =====
// One table entry: color match, bounding box update and valid flag.
module pbbt_cell
  import pbbt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  bbt_req_t   req,
  input  logic       alloc,
  output logic       valid,
  output logic       hit,
  output bbt_entry_t view
);

  logic                  valid_r;
  logic [COLOR_BITS-1:0] color_r;
  bbt_entry_t            entry_r;
  bbt_entry_t            merged;

  assign valid = valid_r;
  assign hit   = valid_r && (color_r == req.color);

  always_comb begin
    merged.min_x  = (req.x < entry_r.min_x) ? req.x : entry_r.min_x;
    merged.min_y  = (req.y < entry_r.min_y) ? req.y : entry_r.min_y;
    merged.max_x  = (req.x > entry_r.max_x) ? req.x : entry_r.max_x;
    merged.max_y  = (req.y > entry_r.max_y) ? req.y : entry_r.max_y;
    merged.last_x = req.x;
    merged.last_y = req.y;
  end

  assign view = req.write ? merged : entry_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (req.clear) begin
      valid_r <= 1'b0;
    end else if (alloc) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (alloc) begin
      color_r        <= req.color;
      entry_r.min_x  <= req.x;
      entry_r.min_y  <= req.y;
      entry_r.max_x  <= req.x;
      entry_r.max_y  <= req.y;
      entry_r.last_x <= req.x;
      entry_r.last_y <= req.y;
    end else if (req.write && hit) begin
      entry_r <= merged;
    end
  end

endmodule

// ===== hdl/per_color_bounding_box_table.sv =====
// Top level of the per-color bounding box table.
// One item is accepted per clock when the result side keeps up: each item passes an
// input register, a color match and box update across all table entries at once,
// and a result register, and every item yields exactly one result. The next item
// always sees the table as left by the previous one. Entries are filled in arrival
// order and a clear empties the table; no clearing pass follows reset.
module per_color_bounding_box_table
  import pbbt_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // Fields from bit 0 up: red, green, blue, pos_x, pos_y.
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // Fields from bit 0 up: cmd.
  input  logic [1:0]               in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // Fields from bit 0 up: box_min_x, box_min_y, box_max_x, box_max_y,
  // seen_last_x, seen_last_y, box_span.
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  // Fields from bit 0 up: status.
  output logic [1:0]               out_tuser
);

  logic                   in_valid_r;
  logic [1:0]             cmd_r;
  logic [COLOR_BITS-1:0]  color_r;
  logic [COORD_BITS-1:0]  x_r;
  logic [COORD_BITS-1:0]  y_r;
  logic                   process;

  logic [SLOT_BITS-1:0]   used_slots_r;
  logic [SLOT_BITS-1:0]   used_slots_nxt;
  logic                   full;
  logic                   alloc_any;

  bbt_req_t               req;
  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] valid_vec;
  logic [TABLE_ENTRIES-1:0] alloc_vec;
  bbt_entry_t             views [TABLE_ENTRIES];
  bbt_entry_t             sel_entry;
  logic                   any_hit;

  status_t                status_nxt;
  bbt_entry_t             res_nxt;
  logic [SPAN_BITS-1:0]   span_nxt;

  logic                   out_valid_r;
  status_t                status_r;
  bbt_entry_t             res_r;
  logic [SPAN_BITS-1:0]   span_r;

  assign process   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || process;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      cmd_r   <= in_tuser;
      color_r <= {in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]};
      x_r     <= in_tdata[COLOR_BITS +: COORD_BITS];
      y_r     <= in_tdata[COLOR_BITS + COORD_BITS +: COORD_BITS];
    end
  end

  assign full = (used_slots_r == SLOT_BITS'(TABLE_ENTRIES));

  always_comb begin
    req.clear = process && (cmd_r == CMD_CLEAR);
    req.write = process && (cmd_r == CMD_PIXEL);
    req.color = color_r;
    req.x     = x_r;
    req.y     = y_r;
  end

  assign any_hit   = |hit_vec;
  assign alloc_any = req.write && !any_hit && !full;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    assign alloc_vec[i] = alloc_any && (used_slots_r == SLOT_BITS'(i));

    pbbt_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (req),
      .alloc (alloc_vec[i]),
      .valid (valid_vec[i]),
      .hit   (hit_vec[i]),
      .view  (views[i])
    );
  end

  always_comb begin
    sel_entry = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      sel_entry = sel_entry | (hit_vec[i] ? views[i] : '0);
    end
  end

  always_comb begin
    used_slots_nxt = used_slots_r;
    if (req.clear) begin
      used_slots_nxt = '0;
    end else if (alloc_any) begin
      used_slots_nxt = used_slots_r + SLOT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_slots_r <= '0;
    end else begin
      used_slots_r <= used_slots_nxt;
    end
  end

  always_comb begin
    status_nxt = ST_NOT_FOUND;
    res_nxt    = '0;
    case (cmd_r)
      CMD_PIXEL: begin
        if (any_hit) begin
          status_nxt = ST_EXISTING;
          res_nxt    = sel_entry;
        end else if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt     = ST_NEW;
          res_nxt.min_x  = x_r;
          res_nxt.min_y  = y_r;
          res_nxt.max_x  = x_r;
          res_nxt.max_y  = y_r;
          res_nxt.last_x = x_r;
          res_nxt.last_y = y_r;
        end
      end
      CMD_QUERY: begin
        if (any_hit) begin
          status_nxt = ST_EXISTING;
          res_nxt    = sel_entry;
        end
      end
      default: begin
        status_nxt = ST_NOT_FOUND;
      end
    endcase
  end

  assign span_nxt = SPAN_BITS'(res_nxt.max_x - res_nxt.min_x)
                  + SPAN_BITS'(res_nxt.max_y - res_nxt.min_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (process) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (process) begin
      status_r <= status_nxt;
      res_r    <= res_nxt;
      span_r   <= span_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = OUT_DATA_BITS'({span_r, res_r.last_y, res_r.last_x, res_r.max_y,
                                      res_r.max_x, res_r.min_y, res_r.min_x});

`ifndef SYNTHESIS
  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_vec) == 32'(used_slots_r))
    else $error("Filled slot count differs from the number of valid entries.");

  a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(hit_vec))
    else $error("A color matches more than one entry.");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_FULL) |-> full)
    else $error("A dropped item was reported while the table had room.");

  a_single_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    alloc_any |=> (used_slots_r == $past(used_slots_r) + SLOT_BITS'(1)))
    else $error("Allocating an entry did not advance the fill count by one.");
`endif

endmodule
